// ----- hw/rtl/qco_pkg.sv -----
// ----------------------------------------------------------------------------
// qco_pkg
// Shared constants and types for the quad corner ordering pipeline.
// ----------------------------------------------------------------------------
package qco_pkg;

  localparam int NUM_PTS   = 4;
  localparam int NUM_PAIRS = NUM_PTS * (NUM_PTS - 1) / 2;

  // corner index / ring position
  typedef logic [1:0] idx_t;

endpackage

// ----- hw/rtl/qco_center.sv -----
// ----------------------------------------------------------------------------
// qco_center
// Stage 1: centroid offsets 4*p - sum(p) for every corner, registered.
// ----------------------------------------------------------------------------
module qco_center #(
  parameter int CoordW = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     valid_i,
  input  logic [CoordW-1:0]        x_i  [qco_pkg::NUM_PTS],
  input  logic [CoordW-1:0]        y_i  [qco_pkg::NUM_PTS],
  output logic                     valid_o,
  output logic [CoordW-1:0]        x_o  [qco_pkg::NUM_PTS],
  output logic [CoordW-1:0]        y_o  [qco_pkg::NUM_PTS],
  output logic signed [CoordW+2:0] dx_o [qco_pkg::NUM_PTS],
  output logic signed [CoordW+2:0] dy_o [qco_pkg::NUM_PTS]
);
  import qco_pkg::*;

  localparam int SumW = CoordW + 2;
  localparam int OffW = CoordW + 3;

  logic [SumW-1:0]        sx, sy;
  logic signed [OffW-1:0] dx_d [NUM_PTS];
  logic signed [OffW-1:0] dy_d [NUM_PTS];

  logic                   valid_q;
  logic [CoordW-1:0]      x_q  [NUM_PTS];
  logic [CoordW-1:0]      y_q  [NUM_PTS];
  logic signed [OffW-1:0] dx_q [NUM_PTS];
  logic signed [OffW-1:0] dy_q [NUM_PTS];

  always_comb begin
    sx = '0;
    sy = '0;
    for (int i = 0; i < NUM_PTS; i++) begin
      sx = sx + SumW'(x_i[i]);
      sy = sy + SumW'(y_i[i]);
    end
    for (int i = 0; i < NUM_PTS; i++) begin
      dx_d[i] = $signed({1'b0, x_i[i], 2'b00}) - $signed({1'b0, sx});
      dy_d[i] = $signed({1'b0, y_i[i], 2'b00}) - $signed({1'b0, sy});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      x_q  <= x_i;
      y_q  <= y_i;
      dx_q <= dx_d;
      dy_q <= dy_d;
    end
  end

  assign valid_o = valid_q;
  assign x_o     = x_q;
  assign y_o     = y_q;
  assign dx_o    = dx_q;
  assign dy_o    = dy_q;

`ifndef SYNTHESIS
  // offsets from the centroid always cancel
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> ((dx_q[0] + dx_q[1] + dx_q[2] + dx_q[3]) == '0 &&
                 (dy_q[0] + dy_q[1] + dy_q[2] + dy_q[3]) == '0))
    else $error("centroid offsets do not sum to zero");
`endif

endmodule

// ----- hw/rtl/qco_sort.sv -----
// ----------------------------------------------------------------------------
// qco_sort
// Stages 2 and 3: pairwise cross products, then stable angle ranking and
// permutation of the corners into angle order.
// ----------------------------------------------------------------------------
module qco_sort #(
  parameter int CoordW = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     valid_i,
  input  logic [CoordW-1:0]        x_i  [qco_pkg::NUM_PTS],
  input  logic [CoordW-1:0]        y_i  [qco_pkg::NUM_PTS],
  input  logic signed [CoordW+2:0] dx_i [qco_pkg::NUM_PTS],
  input  logic signed [CoordW+2:0] dy_i [qco_pkg::NUM_PTS],
  output logic                     valid_o,
  output logic [CoordW-1:0]        x_o  [qco_pkg::NUM_PTS],
  output logic [CoordW-1:0]        y_o  [qco_pkg::NUM_PTS]
);
  import qco_pkg::*;

  localparam int OffW  = CoordW + 3;
  localparam int ProdW = 2 * OffW;

  // half-plane classes in increasing angle
  typedef enum logic [1:0] {
    CLS_LOWER = 2'd0,
    CLS_POS_X = 2'd1,
    CLS_UPPER = 2'd2,
    CLS_NEG_X = 2'd3
  } class_e;

  function automatic int pair_idx(int a, int b);
    return a * (2 * NUM_PTS - 1 - a) / 2 + b - a - 1;
  endfunction

  class_e                  cls_d  [NUM_PTS];
  logic signed [ProdW-1:0] pa_d   [NUM_PAIRS];
  logic signed [ProdW-1:0] pb_d   [NUM_PAIRS];
  logic signed [ProdW:0]   cr     [NUM_PAIRS];
  logic                    bef_ba [NUM_PAIRS];
  idx_t                    rank   [NUM_PTS];
  logic [CoordW-1:0]       xs_d   [NUM_PTS];
  logic [CoordW-1:0]       ys_d   [NUM_PTS];

  logic                    vld_a_q;
  logic [CoordW-1:0]       x_a_q  [NUM_PTS];
  logic [CoordW-1:0]       y_a_q  [NUM_PTS];
  class_e                  cls_a_q[NUM_PTS];
  logic signed [ProdW-1:0] pa_q   [NUM_PAIRS];
  logic signed [ProdW-1:0] pb_q   [NUM_PAIRS];

  logic                    vld_b_q;
  logic [CoordW-1:0]       xs_q   [NUM_PTS];
  logic [CoordW-1:0]       ys_q   [NUM_PTS];

  always_comb begin
    for (int i = 0; i < NUM_PTS; i++) begin
      if (dy_i[i] < 0) begin
        cls_d[i] = CLS_LOWER;
      end else if (dy_i[i] > 0) begin
        cls_d[i] = CLS_UPPER;
      end else if (dx_i[i] >= 0) begin
        cls_d[i] = CLS_POS_X;
      end else begin
        cls_d[i] = CLS_NEG_X;
      end
    end
  end

  for (genvar gi = 0; gi < NUM_PTS - 1; gi++) begin : g_row
    for (genvar gj = gi + 1; gj < NUM_PTS; gj++) begin : g_col
      localparam int K = gi * (2 * NUM_PTS - 1 - gi) / 2 + gj - gi - 1;

      assign pa_d[K] = dx_i[gi] * dy_i[gj];
      assign pb_d[K] = dy_i[gi] * dx_i[gj];

      // cross(i, j) = dx_i*dy_j - dy_i*dx_j; j before i when it is negative
      assign cr[K] = {pa_q[K][ProdW-1], pa_q[K]} - {pb_q[K][ProdW-1], pb_q[K]};
      assign bef_ba[K] = (cls_a_q[gi] == cls_a_q[gj])
                       ? ((cls_a_q[gi] == CLS_LOWER || cls_a_q[gi] == CLS_UPPER)
                          && cr[K][ProdW])
                       : (cls_a_q[gj] < cls_a_q[gi]);
    end
  end

  // stable rank: earlier ties stay ahead
  always_comb begin
    for (int i = 0; i < NUM_PTS; i++) begin
      rank[i] = '0;
      for (int j = 0; j < NUM_PTS; j++) begin
        if (j < i) begin
          if (!bef_ba[pair_idx(j, i)]) rank[i] = rank[i] + idx_t'(1);
        end else if (j > i) begin
          if (bef_ba[pair_idx(i, j)]) rank[i] = rank[i] + idx_t'(1);
        end
      end
    end
    for (int r = 0; r < NUM_PTS; r++) begin
      xs_d[r] = '0;
      ys_d[r] = '0;
      for (int i = 0; i < NUM_PTS; i++) begin
        if (rank[i] == idx_t'(r)) begin
          xs_d[r] = x_a_q[i];
          ys_d[r] = y_a_q[i];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_a_q <= 1'b0;
      vld_b_q <= 1'b0;
    end else begin
      vld_a_q <= valid_i;
      vld_b_q <= vld_a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      x_a_q   <= x_i;
      y_a_q   <= y_i;
      cls_a_q <= cls_d;
      pa_q    <= pa_d;
      pb_q    <= pb_d;
    end
    if (vld_a_q) begin
      xs_q <= xs_d;
      ys_q <= ys_d;
    end
  end

  assign valid_o = vld_b_q;
  assign x_o     = xs_q;
  assign y_o     = ys_q;

`ifndef SYNTHESIS
  // ranks must form a permutation
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_a_q |-> (rank[0] != rank[1] && rank[0] != rank[2] && rank[0] != rank[3] &&
                 rank[1] != rank[2] && rank[1] != rank[3] && rank[2] != rank[3]))
    else $error("angle ranks collide");
`endif

endmodule

// ----- hw/rtl/qco_orient.sv -----
// ----------------------------------------------------------------------------
// qco_orient
// Stages 4 and 5: shoelace products and top-left candidates, then area sign,
// optional reversal and rotation to the corner with least x+y.
// ----------------------------------------------------------------------------
module qco_orient #(
  parameter int CoordW = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  logic [CoordW-1:0] x_i [qco_pkg::NUM_PTS],
  input  logic [CoordW-1:0] y_i [qco_pkg::NUM_PTS],
  output logic              valid_o,
  output logic [CoordW-1:0] x_o [qco_pkg::NUM_PTS],
  output logic [CoordW-1:0] y_o [qco_pkg::NUM_PTS]
);
  import qco_pkg::*;

  localparam int SumW  = CoordW + 1;
  localparam int MulW  = 2 * CoordW;
  localparam int AreaW = MulW + 3;

  function automatic idx_t min_pos(logic [SumW-1:0] s0, logic [SumW-1:0] s1,
                                   logic [SumW-1:0] s2, logic [SumW-1:0] s3);
    idx_t            tl;
    logic [SumW-1:0] best;
    tl   = idx_t'(0);
    best = s0;
    if (s1 < best) begin
      tl   = idx_t'(1);
      best = s1;
    end
    if (s2 < best) begin
      tl   = idx_t'(2);
      best = s2;
    end
    if (s3 < best) begin
      tl = idx_t'(3);
    end
    return tl;
  endfunction

  logic [SumW-1:0]         s      [NUM_PTS];
  logic [MulW-1:0]         ax_d   [NUM_PTS];
  logic [MulW-1:0]         bx_d   [NUM_PTS];
  logic signed [AreaW-1:0] area;
  logic                    flip;
  idx_t                    tl;
  logic [CoordW-1:0]       qx     [NUM_PTS];
  logic [CoordW-1:0]       qy     [NUM_PTS];
  logic [CoordW-1:0]       ox_d   [NUM_PTS];
  logic [CoordW-1:0]       oy_d   [NUM_PTS];

  logic                    vld_c_q;
  logic [CoordW-1:0]       x_c_q  [NUM_PTS];
  logic [CoordW-1:0]       y_c_q  [NUM_PTS];
  logic [MulW-1:0]         ax_q   [NUM_PTS];
  logic [MulW-1:0]         bx_q   [NUM_PTS];
  idx_t                    tlf_q, tlr_q;

  logic                    vld_d_q;
  logic [CoordW-1:0]       ox_q   [NUM_PTS];
  logic [CoordW-1:0]       oy_q   [NUM_PTS];

  always_comb begin
    for (int i = 0; i < NUM_PTS; i++) begin
      s[i]    = SumW'(x_i[i]) + SumW'(y_i[i]);
      ax_d[i] = MulW'(x_i[i]) * MulW'(y_i[(i + 1) % NUM_PTS]);
      bx_d[i] = MulW'(x_i[(i + 1) % NUM_PTS]) * MulW'(y_i[i]);
    end
  end

  // reversed ring swaps positions 1 and 3
  always_comb begin
    area = '0;
    for (int i = 0; i < NUM_PTS; i++) begin
      area = area + $signed(AreaW'(ax_q[i])) - $signed(AreaW'(bx_q[i]));
    end
    flip = !area[AreaW-1] && (area != '0);
    tl   = flip ? tlr_q : tlf_q;
    qx[0] = x_c_q[0];
    qy[0] = y_c_q[0];
    qx[2] = x_c_q[2];
    qy[2] = y_c_q[2];
    qx[1] = flip ? x_c_q[3] : x_c_q[1];
    qy[1] = flip ? y_c_q[3] : y_c_q[1];
    qx[3] = flip ? x_c_q[1] : x_c_q[3];
    qy[3] = flip ? y_c_q[1] : y_c_q[3];
    for (int i = 0; i < NUM_PTS; i++) begin
      ox_d[i] = qx[tl + idx_t'(i)];
      oy_d[i] = qy[tl + idx_t'(i)];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_c_q <= 1'b0;
      vld_d_q <= 1'b0;
    end else begin
      vld_c_q <= valid_i;
      vld_d_q <= vld_c_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      x_c_q <= x_i;
      y_c_q <= y_i;
      ax_q  <= ax_d;
      bx_q  <= bx_d;
      tlf_q <= min_pos(s[0], s[1], s[2], s[3]);
      tlr_q <= min_pos(s[0], s[3], s[2], s[1]);
    end
    if (vld_c_q) begin
      ox_q <= ox_d;
      oy_q <= oy_d;
    end
  end

  assign valid_o = vld_d_q;
  assign x_o     = ox_q;
  assign y_o     = oy_q;

`ifndef SYNTHESIS
  // first corner has the least x+y
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_d_q |->
      ((SumW'(ox_q[0]) + SumW'(oy_q[0])) <= (SumW'(ox_q[1]) + SumW'(oy_q[1])) &&
       (SumW'(ox_q[0]) + SumW'(oy_q[0])) <= (SumW'(ox_q[2]) + SumW'(oy_q[2])) &&
       (SumW'(ox_q[0]) + SumW'(oy_q[0])) <= (SumW'(ox_q[3]) + SumW'(oy_q[3]))))
    else $error("first corner is not the top-left one");
`endif

endmodule

// ----- hw/rtl/quad_corner_ordering.sv -----
// ----------------------------------------------------------------------------
// quad_corner_ordering
// Puts the four corners of a quadrilateral into canonical ring order.
// ----------------------------------------------------------------------------
// Fully pipelined: one quad is taken every clock and busy_o never rises. The
// ordered corners appear on the ordered*_o ports after the five register
// stages (centroid offsets, cross products, angle rank, shoelace products,
// orientation and rotation), marked by a one-cycle done_o pulse. Results are
// not held: the receiver must take each one in its done_o cycle.
// ----------------------------------------------------------------------------
module quad_corner_ordering #(
  parameter int COORD_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  output logic                  busy_o,
  input  logic [COORD_BITS-1:0] pt0_x_i,
  input  logic [COORD_BITS-1:0] pt0_y_i,
  input  logic [COORD_BITS-1:0] pt1_x_i,
  input  logic [COORD_BITS-1:0] pt1_y_i,
  input  logic [COORD_BITS-1:0] pt2_x_i,
  input  logic [COORD_BITS-1:0] pt2_y_i,
  input  logic [COORD_BITS-1:0] pt3_x_i,
  input  logic [COORD_BITS-1:0] pt3_y_i,
  output logic                  done_o,
  output logic [COORD_BITS-1:0] ordered0_x_o,
  output logic [COORD_BITS-1:0] ordered0_y_o,
  output logic [COORD_BITS-1:0] ordered1_x_o,
  output logic [COORD_BITS-1:0] ordered1_y_o,
  output logic [COORD_BITS-1:0] ordered2_x_o,
  output logic [COORD_BITS-1:0] ordered2_y_o,
  output logic [COORD_BITS-1:0] ordered3_x_o,
  output logic [COORD_BITS-1:0] ordered3_y_o
);
  import qco_pkg::*;

  logic                      req;
  logic [COORD_BITS-1:0]     in_x  [NUM_PTS];
  logic [COORD_BITS-1:0]     in_y  [NUM_PTS];

  logic                      c_vld;
  logic [COORD_BITS-1:0]     c_x   [NUM_PTS];
  logic [COORD_BITS-1:0]     c_y   [NUM_PTS];
  logic signed [COORD_BITS+2:0] c_dx [NUM_PTS];
  logic signed [COORD_BITS+2:0] c_dy [NUM_PTS];

  logic                      s_vld;
  logic [COORD_BITS-1:0]     s_x   [NUM_PTS];
  logic [COORD_BITS-1:0]     s_y   [NUM_PTS];

  logic                      o_vld;
  logic [COORD_BITS-1:0]     o_x   [NUM_PTS];
  logic [COORD_BITS-1:0]     o_y   [NUM_PTS];

  assign busy_o = 1'b0;
  assign req    = start_i && !busy_o;

  assign in_x[0] = pt0_x_i;
  assign in_y[0] = pt0_y_i;
  assign in_x[1] = pt1_x_i;
  assign in_y[1] = pt1_y_i;
  assign in_x[2] = pt2_x_i;
  assign in_y[2] = pt2_y_i;
  assign in_x[3] = pt3_x_i;
  assign in_y[3] = pt3_y_i;

  qco_center #(
    .CoordW (COORD_BITS)
  ) u_center (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (req),
    .x_i     (in_x),
    .y_i     (in_y),
    .valid_o (c_vld),
    .x_o     (c_x),
    .y_o     (c_y),
    .dx_o    (c_dx),
    .dy_o    (c_dy)
  );

  qco_sort #(
    .CoordW (COORD_BITS)
  ) u_sort (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (c_vld),
    .x_i     (c_x),
    .y_i     (c_y),
    .dx_i    (c_dx),
    .dy_i    (c_dy),
    .valid_o (s_vld),
    .x_o     (s_x),
    .y_o     (s_y)
  );

  qco_orient #(
    .CoordW (COORD_BITS)
  ) u_orient (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_vld),
    .x_i     (s_x),
    .y_i     (s_y),
    .valid_o (o_vld),
    .x_o     (o_x),
    .y_o     (o_y)
  );

  assign done_o       = o_vld;
  assign ordered0_x_o = o_x[0];
  assign ordered0_y_o = o_y[0];
  assign ordered1_x_o = o_x[1];
  assign ordered1_y_o = o_y[1];
  assign ordered2_x_o = o_x[2];
  assign ordered2_y_o = o_y[2];
  assign ordered3_x_o = o_x[3];
  assign ordered3_y_o = o_y[3];

endmodule

// ----- verif/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for quad_corner_ordering. Directed quads (corners at the
// centroid, collinear and repeated corners, both windings, x+y ties, field
// extremes) are followed by random quads. Every accepted request is run through
// a local ordering model and each done_o result is compared corner by corner.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CW         = 16;
  localparam int NUM_RAND   = 400;
  localparam int TAIL_CYC   = 10;
  localparam int CYCLE_LIM  = 200000;

  typedef struct packed {
    logic [CW-1:0] x;
    logic [CW-1:0] y;
  } corner_t;
  typedef corner_t [qco_pkg::NUM_PTS-1:0] quad_t;

  logic clk_i   = 1'b0;
  logic rst_ni  = 1'b0;
  logic start_i = 1'b0;
  quad_t in_quad = '0;
  logic busy_o;
  logic done_o;
  wire [CW-1:0] ordered_x [4];
  wire [CW-1:0] ordered_y [4];

  quad_t pending_quads[$];
  quad_t expected_rings[$];
  int    err_cnt    = 0;
  int    gap_left   = 0;
  int    burst_left = 0;
  longint cycle_cnt = 0;

  quad_corner_ordering #(.COORD_BITS(CW)) uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .pt0_x_i     (in_quad[0].x),
    .pt0_y_i     (in_quad[0].y),
    .pt1_x_i     (in_quad[1].x),
    .pt1_y_i     (in_quad[1].y),
    .pt2_x_i     (in_quad[2].x),
    .pt2_y_i     (in_quad[2].y),
    .pt3_x_i     (in_quad[3].x),
    .pt3_y_i     (in_quad[3].y),
    .done_o      (done_o),
    .ordered0_x_o(ordered_x[0]),
    .ordered0_y_o(ordered_y[0]),
    .ordered1_x_o(ordered_x[1]),
    .ordered1_y_o(ordered_y[1]),
    .ordered2_x_o(ordered_x[2]),
    .ordered2_y_o(ordered_y[2]),
    .ordered3_x_o(ordered_x[3]),
    .ordered3_y_o(ordered_y[3])
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // 0: below, 1: zero angle (incl. centroid), 2: above, 3: angle pi
  function automatic int half_plane(longint dx, longint dy);
    if (dy < 0) return 0;
    if (dy > 0) return 2;
    return (dx >= 0) ? 1 : 3;
  endfunction

  function automatic bit angle_lt(longint ax, longint ay, longint bx, longint by);
    int ca;
    int cb;
    ca = half_plane(ax, ay);
    cb = half_plane(bx, by);
    if (ca != cb) return ca < cb;
    if (ca == 1 || ca == 3) return 1'b0;
    return (ax * by - ay * bx) > 0;
  endfunction

  function automatic quad_t order_corners(quad_t q);
    corner_t pt [4];
    longint  dx [4];
    longint  dy [4];
    corner_t kc;
    longint  kx;
    longint  ky;
    longint  sx;
    longint  sy;
    longint  area;
    int      j;
    int      tl;
    int      best;
    int      s;
    quad_t   ring;
    sx = 0;
    sy = 0;
    for (int i = 0; i < 4; i++) begin
      pt[i] = q[i];
      sx += longint'(q[i].x);
      sy += longint'(q[i].y);
    end
    for (int i = 0; i < 4; i++) begin
      dx[i] = 4 * longint'(pt[i].x) - sx;
      dy[i] = 4 * longint'(pt[i].y) - sy;
    end
    for (int i = 1; i < 4; i++) begin
      kc = pt[i];
      kx = dx[i];
      ky = dy[i];
      j  = i;
      while (j > 0 && angle_lt(kx, ky, dx[j-1], dy[j-1])) begin
        pt[j] = pt[j-1];
        dx[j] = dx[j-1];
        dy[j] = dy[j-1];
        j--;
      end
      pt[j] = kc;
      dx[j] = kx;
      dy[j] = ky;
    end
    area = 0;
    for (int i = 0; i < 4; i++) begin
      area += longint'(pt[i].x) * longint'(pt[(i+1)%4].y)
            - longint'(pt[(i+1)%4].x) * longint'(pt[i].y);
    end
    if (area > 0) begin
      kc    = pt[1];
      pt[1] = pt[3];
      pt[3] = kc;
    end
    tl   = 0;
    best = int'(pt[0].x) + int'(pt[0].y);
    for (int i = 1; i < 4; i++) begin
      s = int'(pt[i].x) + int'(pt[i].y);
      if (s < best) begin
        best = s;
        tl   = i;
      end
    end
    for (int i = 0; i < 4; i++) ring[i] = pt[(tl + i) % 4];
    return ring;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    err_cnt++;
  endtask

  task automatic push_quad(input int x0, y0, x1, y1, x2, y2, x3, y3);
    quad_t q;
    q[0] = '{x: x0[CW-1:0], y: y0[CW-1:0]};
    q[1] = '{x: x1[CW-1:0], y: y1[CW-1:0]};
    q[2] = '{x: x2[CW-1:0], y: y2[CW-1:0]};
    q[3] = '{x: x3[CW-1:0], y: y3[CW-1:0]};
    pending_quads.push_back(q);
  endtask

  function automatic quad_t rand_quad();
    quad_t   q;
    corner_t tmp;
    int      mode;
    int      a;
    int      b;
    int      c;
    int      k;
    int      xa;
    int      xb;
    int      ya;
    int      yb;
    mode = $urandom_range(0, 9);
    for (int i = 0; i < 4; i++) begin
      q[i].x = CW'($urandom);
      q[i].y = CW'($urandom);
    end
    case (mode)
      5, 6: begin
        for (int i = 0; i < 4; i++) begin
          q[i].x = CW'($urandom_range(0, 7));
          q[i].y = CW'($urandom_range(0, 7));
        end
      end
      7: begin
        xa = $urandom_range(0, 65535);
        xb = $urandom_range(0, 65535);
        ya = $urandom_range(0, 65535);
        yb = $urandom_range(0, 65535);
        q[0] = '{x: xa[CW-1:0], y: ya[CW-1:0]};
        q[1] = '{x: xb[CW-1:0], y: ya[CW-1:0]};
        q[2] = '{x: xb[CW-1:0], y: yb[CW-1:0]};
        q[3] = '{x: xa[CW-1:0], y: yb[CW-1:0]};
      end
      8: begin
        k = $urandom_range(1, 3);
        q[k] = q[$urandom_range(0, k - 1)];
      end
      9: begin
        c  = $urandom_range(20000, 45000);
        a  = $urandom_range(0, 20000) - 10000;
        b  = $urandom_range(0, 20000) - 10000;
        xa = c + a;
        xb = c + b;
        ya = c - a - b;
        c  = $urandom_range(20000, 45000);
        a  = $urandom_range(0, 20000) - 10000;
        b  = $urandom_range(0, 20000) - 10000;
        q[0] = '{x: xa[CW-1:0], y: CW'(c + a)};
        q[1] = '{x: xb[CW-1:0], y: CW'(c + b)};
        q[2] = '{x: ya[CW-1:0], y: CW'(c - a - b)};
        xa = int'(q[0].x) + int'(q[1].x) + int'(q[2].x);
        q[3] = '{x: CW'(xa / 3), y: CW'(c)};
      end
      default: ;
    endcase
    for (int i = 0; i < 3; i++) begin
      k       = $urandom_range(i, 3);
      tmp     = q[i];
      q[i]    = q[k];
      q[k]    = tmp;
    end
    return q;
  endfunction

  // mostly back-to-back or short gaps, occasionally long, with idle-free bursts
  function automatic int next_gap();
    int r;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      burst_left = $urandom_range(20, 60);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_i  <= 1'b0;
      gap_left <= 0;
    end else begin
      if (start_i && !busy_o) expected_rings.push_back(order_corners(in_quad));
      if (start_i && busy_o) begin
      end else if (gap_left != 0) begin
        gap_left <= gap_left - 1;
        start_i  <= 1'b0;
      end else if (pending_quads.size() != 0) begin
        in_quad  <= pending_quads.pop_front();
        start_i  <= 1'b1;
        gap_left <= next_gap();
      end else begin
        start_i <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    quad_t want;
    if (rst_ni && done_o) begin
      if (expected_rings.size() == 0) begin
        report_mismatch("result with no request outstanding");
      end else begin
        want = expected_rings.pop_front();
        for (int i = 0; i < 4; i++) begin
          if (ordered_x[i] !== want[i].x)
            report_mismatch($sformatf("ordered%0d_x got %h want %h", i, ordered_x[i],
                                      want[i].x));
          if (ordered_y[i] !== want[i].y)
            report_mismatch($sformatf("ordered%0d_y got %h want %h", i, ordered_y[i],
                                      want[i].y));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIM) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    push_quad(0, 0, 0, 0, 0, 0, 0, 0);
    push_quad(65535, 65535, 65535, 65535, 65535, 65535, 65535, 65535);
    push_quad(0, 0, 65535, 0, 65535, 65535, 0, 65535);
    push_quad(0, 65535, 65535, 65535, 65535, 0, 0, 0);
    push_quad(65535, 0, 0, 65535, 65535, 65535, 0, 0);
    push_quad(16, 16, 160, 16, 160, 160, 16, 160);
    push_quad(16, 160, 160, 160, 160, 16, 16, 16);
    push_quad(160, 160, 16, 16, 16, 160, 160, 16);
    push_quad(0, 0, 30, 0, 0, 30, 10, 10);
    push_quad(10, 10, 0, 0, 30, 0, 0, 30);
    push_quad(0, 0, 10, 10, 20, 20, 30, 30);
    push_quad(30, 30, 0, 0, 20, 20, 10, 10);
    push_quad(5, 5, 5, 5, 9, 1, 1, 9);
    push_quad(0, 10, 10, 0, 20, 10, 10, 20);
    push_quad(50, 0, 100, 50, 50, 100, 0, 50);
    push_quad(0, 50, 100, 50, 200, 50, 300, 50);
    push_quad(70, 0, 70, 300, 70, 100, 70, 200);
    push_quad(16'haaaa, 16'h5555, 16'h5555, 16'haaaa, 16'haaaa, 16'haaaa,
              16'h5555, 16'h5555);
    push_quad(16'h5555, 16'haaaa, 16'haaaa, 16'h5555, 16'h5555, 16'h5555,
              16'haaaa, 16'haaaa);
    push_quad(0, 0, 100, 100, 100, 0, 0, 100);
    push_quad(0, 0, 40, 0, 20, 40, 20, 40);
    push_quad(65535, 0, 0, 0, 32768, 65535, 32768, 21845);
    push_quad(1, 65534, 65534, 1, 65535, 65535, 0, 0);
    repeat (NUM_RAND) pending_quads.push_back(rand_quad());

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    do @(negedge clk_i);
    while (pending_quads.size() != 0 || start_i || expected_rings.size() != 0);
    repeat (TAIL_CYC) @(posedge clk_i);

    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
